FILE: hdl/voxel_occupancy_segment_check_assert.svh
// assertion macros shared by the voxel occupancy checker modules
// no dependencies; included by modules that carry concurrent checks
`ifndef VOXEL_OCCUPANCY_SEGMENT_CHECK_ASSERT_SVH
`define VOXEL_OCCUPANCY_SEGMENT_CHECK_ASSERT_SVH

// same-cycle implication
`define VOSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vosc check failed");

// next-cycle implication
`define VOSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vosc check failed");

`endif

FILE: hdl/vosc_pkg.sv
// types and constants for the voxel occupancy segment checker
// no dependencies
package vosc_pkg;

	typedef logic signed [31:0] coord_t;
	typedef logic [30:0] scale_t;
	typedef logic [31:0] mag_t;

	typedef enum logic [1:0] {
		FUNC_MARK    = 2'd0,
		FUNC_QUERY   = 2'd1,
		FUNC_SEGMENT = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		CFG_LOWER_X  = 3'd0,
		CFG_LOWER_Y  = 3'd1,
		CFG_LOWER_Z  = 3'd2,
		CFG_UPPER_X  = 3'd3,
		CFG_UPPER_Y  = 3'd4,
		CFG_UPPER_Z  = 3'd5,
		CFG_VOXEL    = 3'd6,
		CFG_INVVOXEL = 3'd7
	} cfg_reg_t;

	localparam coord_t RST_LOWER = 32'sd0;
	localparam coord_t RST_UPPER = 32'sd4194304;
	localparam scale_t RST_SCALE = 31'd65536;

	localparam int QDEPTH = 2;
	localparam int MUL_AW = 34;
	localparam int MUL_BW = 33;

	typedef struct packed {
		coord_t [2:0] lower;
		coord_t [2:0] upper;
		scale_t       voxel_size;
		scale_t       inv_voxel_size;
	} cfg_t;

	typedef struct packed {
		func_t        func;
		logic         drop;
		coord_t [2:0] p1;
		coord_t [2:0] p2;
		mag_t [2:0]   dmag;
		logic [2:0]   dneg;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic done;
		logic blocked;
		logic mark_dropped;
		logic steps_capped;
	} res_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_SQ_SUM,
		ST_SQRT,
		ST_LEN,
		ST_DIV_N,
		ST_N_TAKE,
		ST_DIV_R,
		ST_SAMP_INIT,
		ST_OFF_MUL,
		ST_OFF_TAKE,
		ST_IDX_MUL,
		ST_IDX_TAKE,
		ST_READ,
		ST_CHECK,
		ST_RESULT
	} back_state_t;

endpackage

FILE: hdl/vosc_mul.sv
// registered signed multiplier shared by the back end
// depends on vosc_pkg
module vosc_mul import vosc_pkg::*; (
	input  logic                            clk,
	input  logic signed [MUL_AW-1:0]        a,
	input  logic signed [MUL_BW-1:0]        b,
	output logic signed [MUL_AW+MUL_BW-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

FILE: hdl/vosc_queue.sv
// short command queue between the front and back ends
// depends on vosc_pkg and the assertion macro header
`include "voxel_occupancy_segment_check_assert.svh"
module vosc_queue import vosc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   din,
	input  logic   pop,
	output cmd_t   dout,
	output qstat_t stat
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          entry_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	assign dout       = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(QDEPTH));
	assign stat.empty = (count_q == '0);

	`VOSC_ASSERT_IMPL(a_push_room, clk, arst_n, push, !stat.full)
	`VOSC_ASSERT_IMPL(a_pop_data, clk, arst_n, pop, !stat.empty)
	`VOSC_ASSERT_NEXT(a_push_seen, clk, arst_n, push && !pop, !stat.empty)

endmodule

FILE: hdl/vosc_front.sv
// front end: takes requests, checks mark bounds, forms segment deltas
// depends on vosc_pkg
module vosc_front import vosc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [1:0]   func,
	input  coord_t [2:0] p1,
	input  coord_t [2:0] p2,
	input  cfg_t         cfg,
	input  logic         clearing,
	input  logic         q_full,
	output logic         busy,
	output logic         push,
	output cmd_t         cmd
);

	logic         v_s1;
	logic [1:0]   func_s1;
	coord_t [2:0] p1_s1;
	coord_t [2:0] p2_s1;
	logic         accept;
	logic [2:0]   outside;

	assign busy   = clearing || (v_s1 && q_full);
	assign accept = start && !busy;
	assign push   = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			p1_s1   <= p1;
			p2_s1   <= p2;
		end
	end

	always_comb begin
		logic signed [32:0] d;
		logic [32:0]        m;
		cmd.func = func_t'(func_s1);
		cmd.p1   = p1_s1;
		cmd.p2   = p2_s1;
		for (int k = 0; k < 3; k++) begin
			d = {p2_s1[k][31], p2_s1[k]} - {p1_s1[k][31], p1_s1[k]};
			m = d[32] ? 33'(-d) : 33'(d);
			cmd.dneg[k] = d[32];
			cmd.dmag[k] = m[31:0];
			outside[k]  = ($signed(p1_s1[k]) < $signed(cfg.lower[k])) ||
			              ($signed(p1_s1[k]) >= $signed(cfg.upper[k]));
		end
		cmd.drop = |outside;
	end

endmodule

FILE: hdl/vosc_back.sv
// back end: sequencer with shared multiplier, root and divide steps,
// and the row-organized occupancy memory; depends on vosc_pkg, vosc_mul
`include "voxel_occupancy_segment_check_assert.svh"
module vosc_back import vosc_pkg::*; #(
	parameter int GRID_X    = 64,
	parameter int GRID_Y    = 64,
	parameter int GRID_Z    = 64,
	parameter int MAX_STEPS = 256
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  cmd_t   q_dout,
	input  qstat_t qstat,
	output logic   pop,
	output logic   clearing,
	output res_t   res
);

	localparam int XW   = $clog2(GRID_X);
	localparam int YW   = $clog2(GRID_Y);
	localparam int ZW   = $clog2(GRID_Z);
	localparam int ROWS = GRID_X * GRID_Y;
	localparam int RW   = $clog2(ROWS);
	localparam int SW   = $clog2(MAX_STEPS + 1);

	back_state_t state_q, state_d;
	logic [RW-1:0] clr_q;

	cmd_t               cmd_q;
	logic [1:0]         axis_q;
	logic               sample_q;
	logic signed [33:0] coord_q [3];
	logic [XW-1:0]      ix_q;
	logic [YW-1:0]      iy_q;
	logic [ZW-1:0]      iz_q;
	logic               over_q;
	logic [63:0]        sum_hi_q;
	logic [3:0]         sum_lo_q;
	logic [63:0]        sq_v_q, sq_res_q;
	logic [6:0]         cnt_q;
	logic [32:0]        div_rem_q;
	logic [63:0]        div_quo_q;
	logic [32:0]        lq_q;
	logic [SW-1:0]      samples_q, i_q;
	logic [30:0]        r_q;
	logic [32:0]        rr_q;
	logic               blocked_q, dropped_q, capped_q;

	logic [GRID_Z-1:0]  grid_mem [ROWS];
	logic [GRID_Z-1:0]  row_rd_q;
	logic [RW-1:0]      row_addr, mem_wa;
	logic [GRID_Z-1:0]  mem_wd;
	logic               mem_we;

	logic signed [MUL_AW-1:0]        mul_a;
	logic signed [MUL_BW-1:0]        mul_b;
	logic signed [MUL_AW+MUL_BW-1:0] mul_p;

	// shared-unit step signals
	scale_t             vs_eff;
	logic [63:0]        sq_bit, sq_t;
	logic [32:0]        den;
	logic [33:0]        rem_sh;
	logic               div_ge;
	logic [32:0]        rem_nx;
	logic [32:0]        off;
	logic signed [33:0] c_ext;
	logic signed [34:0] diff;
	logic [31:0]        idx_raw, grid_sz, idx_clamp;
	logic               idx_over;
	logic [33:0]        r_sum;
	logic               r_ge;
	logic               last_sample;
	logic               bit_hit;

	vosc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	assign vs_eff   = (cfg.voxel_size == '0) ? scale_t'(1) : cfg.voxel_size;
	assign sq_bit   = 64'h4000_0000_0000_0000 >> {cnt_q[4:0], 1'b0};
	assign sq_t     = sq_res_q + sq_bit;
	assign den      = (state_q == ST_DIV_N) ? {2'b00, vs_eff} : lq_q;
	assign rem_sh   = {div_rem_q, div_quo_q[63]};
	assign div_ge   = rem_sh >= {1'b0, den};
	assign rem_nx   = div_ge ? 33'(rem_sh - {1'b0, den}) : rem_sh[32:0];
	assign off      = mul_p[62:30];
	assign c_ext    = {{2{cmd_q.p1[axis_q][31]}}, cmd_q.p1[axis_q]};
	assign diff     = {coord_q[axis_q][33], coord_q[axis_q]} -
	                  {{3{cfg.lower[axis_q][31]}}, cfg.lower[axis_q]};
	assign idx_raw  = mul_p[66] ? 32'd0 : mul_p[63:32];
	assign idx_over = idx_raw >= grid_sz;
	assign idx_clamp = idx_over ? grid_sz - 32'd1 : idx_raw;
	assign r_sum    = {1'b0, rr_q} + {1'b0, div_rem_q};
	assign r_ge     = r_sum >= {1'b0, lq_q};
	assign last_sample = (i_q == samples_q - SW'(1));
	assign bit_hit  = row_rd_q[iz_q];
	assign row_addr = RW'(ix_q) * RW'(GRID_Y) + RW'(iy_q);

	always_comb begin
		case (axis_q)
			2'd0:    grid_sz = 32'(GRID_X);
			2'd1:    grid_sz = 32'(GRID_Y);
			default: grid_sz = 32'(GRID_Z);
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ_MUL: begin
				mul_a = $signed({2'b00, cmd_q.dmag[axis_q]});
				mul_b = $signed({1'b0, cmd_q.dmag[axis_q]});
			end
			ST_OFF_MUL: begin
				mul_a = $signed({2'b00, cmd_q.dmag[axis_q]});
				mul_b = $signed({2'b00, r_q});
			end
			ST_IDX_MUL: begin
				mul_a = diff[33:0];
				mul_b = $signed({2'b00, cfg.inv_voxel_size});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == RW'(ROWS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (!qstat.empty) begin
					unique case (q_dout.func)
						FUNC_MARK:    state_d = q_dout.drop ? ST_RESULT : ST_IDX_MUL;
						FUNC_QUERY:   state_d = ST_IDX_MUL;
						FUNC_SEGMENT: state_d = ST_SQ_MUL;
						default:      state_d = ST_RESULT;
					endcase
				end
			end
			ST_SQ_MUL:    state_d = ST_SQ_ACC;
			ST_SQ_ACC:    state_d = (axis_q == 2'd2) ? ST_SQ_SUM : ST_SQ_MUL;
			ST_SQ_SUM:    state_d = ST_SQRT;
			ST_SQRT:      if (cnt_q[4:0] == 5'd31) state_d = ST_LEN;
			ST_LEN:       state_d = (sq_res_q[31:0] == '0) ? ST_SAMP_INIT : ST_DIV_N;
			ST_DIV_N:     if (cnt_q == 7'd63) state_d = ST_N_TAKE;
			ST_N_TAKE: begin
				if (div_quo_q != '0 && MAX_STEPS > 1) state_d = ST_DIV_R;
				else state_d = ST_SAMP_INIT;
			end
			ST_DIV_R:     if (cnt_q == 7'd63) state_d = ST_SAMP_INIT;
			ST_SAMP_INIT: state_d = ST_OFF_MUL;
			ST_OFF_MUL:   state_d = ST_OFF_TAKE;
			ST_OFF_TAKE:  state_d = ST_IDX_MUL;
			ST_IDX_MUL:   state_d = ST_IDX_TAKE;
			ST_IDX_TAKE: begin
				if (axis_q == 2'd2) state_d = ST_READ;
				else state_d = sample_q ? ST_OFF_MUL : ST_IDX_MUL;
			end
			ST_READ: begin
				state_d = (cmd_q.func == FUNC_MARK && over_q) ? ST_RESULT : ST_CHECK;
			end
			ST_CHECK: begin
				if (cmd_q.func != FUNC_SEGMENT || !sample_q) state_d = ST_RESULT;
				else state_d = last_sample ? ST_IDX_MUL : ST_OFF_MUL;
			end
			ST_RESULT:    state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + RW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q     <= q_dout;
				axis_q    <= 2'd0;
				sample_q  <= 1'b0;
				blocked_q <= 1'b0;
				dropped_q <= q_dout.drop && q_dout.func == FUNC_MARK;
				capped_q  <= 1'b0;
				sum_hi_q  <= '0;
				sum_lo_q  <= '0;
				for (int k = 0; k < 3; k++) begin
					coord_q[k] <= {{2{q_dout.p1[k][31]}}, q_dout.p1[k]};
				end
			end
			ST_SQ_ACC: begin
				sum_hi_q <= sum_hi_q + {2'b00, mul_p[63:2]};
				sum_lo_q <= sum_lo_q + {2'b00, mul_p[1:0]};
				axis_q   <= axis_q + 2'd1;
			end
			ST_SQ_SUM: begin
				sq_v_q   <= sum_hi_q + {62'd0, sum_lo_q[3:2]};
				sq_res_q <= '0;
				cnt_q    <= '0;
			end
			ST_SQRT: begin
				cnt_q <= cnt_q + 7'd1;
				if (sq_v_q >= sq_t) begin
					sq_v_q   <= sq_v_q - sq_t;
					sq_res_q <= (sq_res_q >> 1) + sq_bit;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
			end
			ST_LEN: begin
				lq_q      <= {sq_res_q[31:0], 1'b0};
				samples_q <= SW'(1);
				div_quo_q <= {31'd0, sq_res_q[31:15], 16'd0};
				div_rem_q <= '0;
				cnt_q     <= '0;
			end
			ST_DIV_N, ST_DIV_R: begin
				div_rem_q <= rem_nx;
				div_quo_q <= {div_quo_q[62:0], div_ge};
				cnt_q     <= cnt_q + 7'd1;
			end
			ST_N_TAKE: begin
				if (div_quo_q >= 64'(MAX_STEPS)) begin
					samples_q <= SW'(MAX_STEPS);
					capped_q  <= 1'b1;
				end else begin
					samples_q <= SW'(div_quo_q) + SW'(1);
				end
				div_quo_q <= {3'd0, vs_eff, 30'd0};
				div_rem_q <= '0;
				cnt_q     <= '0;
			end
			ST_SAMP_INIT: begin
				i_q      <= '0;
				r_q      <= '0;
				rr_q     <= '0;
				axis_q   <= 2'd0;
				sample_q <= 1'b1;
			end
			ST_OFF_TAKE: begin
				if (cmd_q.dneg[axis_q]) coord_q[axis_q] <= c_ext - $signed({1'b0, off});
				else coord_q[axis_q] <= c_ext + $signed({1'b0, off});
			end
			ST_IDX_TAKE: begin
				case (axis_q)
					2'd0:    ix_q <= XW'(idx_clamp);
					2'd1:    iy_q <= YW'(idx_clamp);
					default: iz_q <= ZW'(idx_clamp);
				endcase
				over_q <= (axis_q == 2'd0) ? idx_over : (over_q || idx_over);
				if (axis_q != 2'd2) axis_q <= axis_q + 2'd1;
			end
			ST_READ: begin
				if (cmd_q.func == FUNC_MARK && over_q) dropped_q <= 1'b1;
			end
			ST_CHECK: begin
				if (cmd_q.func != FUNC_MARK) blocked_q <= blocked_q || bit_hit;
				axis_q <= 2'd0;
				if (cmd_q.func == FUNC_SEGMENT && sample_q) begin
					if (last_sample) begin
						// endpoint is tested as a plain point
						sample_q <= 1'b0;
						for (int k = 0; k < 3; k++) begin
							coord_q[k] <= {{2{cmd_q.p2[k][31]}}, cmd_q.p2[k]};
						end
					end else begin
						i_q  <= i_q + SW'(1);
						rr_q <= r_ge ? 33'(r_sum - {1'b0, lq_q}) : r_sum[32:0];
						r_q  <= r_q + div_quo_q[30:0] + 31'(r_ge);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = row_addr;
		mem_wd = row_rd_q | (GRID_Z'(1) << iz_q);
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == ST_CHECK && cmd_q.func == FUNC_MARK) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) grid_mem[mem_wa] <= mem_wd;
		row_rd_q <= grid_mem[row_addr];
	end

	assign pop              = (state_q == ST_IDLE) && !qstat.empty;
	assign clearing         = (state_q == ST_CLEAR);
	assign res.done         = (state_q == ST_RESULT);
	assign res.blocked      = blocked_q;
	assign res.mark_dropped = dropped_q;
	assign res.steps_capped = capped_q;

	`VOSC_ASSERT_IMPL(a_no_pop_clear, clk, arst_n, clearing, !pop)
	`VOSC_ASSERT_NEXT(a_single_result, clk, arst_n, res.done, !res.done)
	`VOSC_ASSERT_IMPL(a_drop_alone, clk, arst_n, res.done && res.mark_dropped, !res.blocked && !res.steps_capped)

endmodule

FILE: hdl/voxel_occupancy_segment_check.sv
// top level of the voxel occupancy segment checker
// depends on vosc_pkg, vosc_front, vosc_queue, vosc_back
//
//  channel   handshake            payload
//  request   start / busy         func, x1, y1, z1, x2, y2, z2
//  result    done (strobe)        blocked, mark_dropped, steps_capped
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a segment runs the 64-step divider up to twice and, for each of its S samples,
// uses the one shared multiplier six times.
// after reset a clearing pass over all GRID_X*GRID_Y rows holds busy high.
// the front register and a two-entry queue let requests land while
// the back end works; results cannot be stalled.
module voxel_occupancy_segment_check import vosc_pkg::*; #(
	parameter int GRID_X    = 64,
	parameter int GRID_Y    = 64,
	parameter int GRID_Z    = 64,
	parameter int MAX_STEPS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  coord_t      x1,
	input  coord_t      y1,
	input  coord_t      z1,
	input  coord_t      x2,
	input  coord_t      y2,
	input  coord_t      z2,
	output logic        done,
	output logic        blocked,
	output logic        mark_dropped,
	output logic        steps_capped,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t   cfg_q;
	cmd_t   push_cmd, q_dout;
	qstat_t qstat;
	res_t   res;
	logic   push, pop, clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower          <= {3{RST_LOWER}};
			cfg_q.upper          <= {3{RST_UPPER}};
			cfg_q.voxel_size     <= RST_SCALE;
			cfg_q.inv_voxel_size <= RST_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_LOWER_X:  cfg_q.lower[0] <= cfg_data;
				CFG_LOWER_Y:  cfg_q.lower[1] <= cfg_data;
				CFG_LOWER_Z:  cfg_q.lower[2] <= cfg_data;
				CFG_UPPER_X:  cfg_q.upper[0] <= cfg_data;
				CFG_UPPER_Y:  cfg_q.upper[1] <= cfg_data;
				CFG_UPPER_Z:  cfg_q.upper[2] <= cfg_data;
				CFG_VOXEL:    cfg_q.voxel_size <= cfg_data[30:0];
				CFG_INVVOXEL: cfg_q.inv_voxel_size <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	vosc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.func     (func),
		.p1       ({z1, y1, x1}),
		.p2       ({z2, y2, x2}),
		.cfg      (cfg_q),
		.clearing (clearing),
		.q_full   (qstat.full),
		.busy     (busy),
		.push     (push),
		.cmd      (push_cmd)
	);

	vosc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.pop    (pop),
		.dout   (q_dout),
		.stat   (qstat)
	);

	vosc_back #(
		.GRID_X    (GRID_X),
		.GRID_Y    (GRID_Y),
		.GRID_Z    (GRID_Z),
		.MAX_STEPS (MAX_STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_dout   (q_dout),
		.qstat    (qstat),
		.pop      (pop),
		.clearing (clearing),
		.res      (res)
	);

	assign done         = res.done;
	assign blocked      = res.blocked;
	assign mark_dropped = res.mark_dropped;
	assign steps_capped = res.steps_capped;

endmodule

FILE: tb/vosc_checker.sv
`timescale 1ns / 100ps
// request/result checker for the voxel occupancy segment checker: holds its own grid copy
// and register set, predicts one verdict per request and compares in order; uses vosc_pkg
module vosc_checker import vosc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  func,
	input  coord_t      x1,
	input  coord_t      y1,
	input  coord_t      z1,
	input  coord_t      x2,
	input  coord_t      y2,
	input  coord_t      z2,
	input  logic        done,
	input  logic        blocked,
	input  logic        mark_dropped,
	input  logic        steps_capped,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);

	localparam longint GRID = 64;
	localparam longint STEP_CAP = 256;

	typedef struct packed {
		logic blocked;
		logic dropped;
		logic capped;
	} verdict_t;

	longint          lower_c [3];
	longint          upper_c [3];
	longint unsigned step_sz;
	longint unsigned inv_step;
	bit [262143:0]   occ;
	verdict_t        expected_verdicts[$];

	assign pending = expected_verdicts.size();

	// index before clamping, zero when the scaled offset is negative
	function automatic longint raw_index(longint p, longint lo);
		longint q;
		q = (p - lo) * longint'(inv_step);
		return (q < 0) ? 0 : (q >>> 32);
	endfunction

	function automatic longint clamped_index(longint p, longint lo);
		longint i;
		i = raw_index(p, lo);
		return (i >= GRID) ? GRID - 1 : i;
	endfunction

	function automatic bit voxel_occupied(longint x, longint y, longint z);
		longint vox_idx;
		vox_idx = clamped_index(x, lower_c[0]) * 4096 + clamped_index(y, lower_c[1]) * 64
			+ clamped_index(z, lower_c[2]);
		return occ[vox_idx];
	endfunction

	function automatic bit mark_voxel(longint x, longint y, longint z);
		longint ix, iy, iz;
		if (x < lower_c[0] || y < lower_c[1] || z < lower_c[2] ||
				x >= upper_c[0] || y >= upper_c[1] || z >= upper_c[2])
			return 1'b1;
		ix = raw_index(x, lower_c[0]);
		iy = raw_index(y, lower_c[1]);
		iz = raw_index(z, lower_c[2]);
		if (ix >= GRID || iy >= GRID || iz >= GRID)
			return 1'b1;
		occ[ix * 4096 + iy * 64 + iz] = 1'b1;
		return 1'b0;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// offset from the start truncated toward zero
	function automatic longint along(longint p, longint d, longint unsigned r);
		longint unsigned mag, off;
		mag = (d < 0) ? longint'(-d) : d;
		off = (mag * r) >> 30;
		return (d < 0) ? p - longint'(off) : p + longint'(off);
	endfunction

	function automatic verdict_t judge_segment(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz);
		verdict_t v;
		longint dx, dy, dz;
		longint unsigned mx, my, mz, sa, sb, sc, quarter, lq, vs, n, samples, r;
		v = '0;
		dx = bx - ax;
		dy = by - ay;
		dz = bz - az;
		mx = (dx < 0) ? longint'(-dx) : dx;
		my = (dy < 0) ? longint'(-dy) : dy;
		mz = (dz < 0) ? longint'(-dz) : dz;
		sa = mx * mx;
		sb = my * my;
		sc = mz * mz;
		quarter = (sa >> 2) + (sb >> 2) + (sc >> 2) + (((sa & 3) + (sb & 3) + (sc & 3)) >> 2);
		lq = 2 * int_sqrt(quarter);
		vs = (step_sz != 0) ? step_sz : 1;
		n = (lq != 0) ? ((lq >> 16) << 16) / vs : 0;
		samples = n + 1;
		if (samples > STEP_CAP) begin
			samples = STEP_CAP;
			v.capped = 1'b1;
		end
		for (longint unsigned i = 0; i < samples; i++) begin
			r = (i == 0 || lq == 0) ? 0 : ((i * vs) << 30) / lq;
			if (voxel_occupied(along(ax, dx, r), along(ay, dy, r), along(az, dz, r)))
				v.blocked = 1'b1;
		end
		if (voxel_occupied(bx, by, bz))
			v.blocked = 1'b1;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			occ = '0;
			for (int a = 0; a < 3; a++) begin
				lower_c[a] = longint'(RST_LOWER);
				upper_c[a] = longint'(RST_UPPER);
			end
			step_sz = RST_SCALE;
			inv_step = RST_SCALE;
			expected_verdicts.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_LOWER_X:  lower_c[0] = longint'(signed'(cfg_data));
					CFG_LOWER_Y:  lower_c[1] = longint'(signed'(cfg_data));
					CFG_LOWER_Z:  lower_c[2] = longint'(signed'(cfg_data));
					CFG_UPPER_X:  upper_c[0] = longint'(signed'(cfg_data));
					CFG_UPPER_Y:  upper_c[1] = longint'(signed'(cfg_data));
					CFG_UPPER_Z:  upper_c[2] = longint'(signed'(cfg_data));
					CFG_VOXEL:    step_sz = cfg_data[30:0];
					CFG_INVVOXEL: inv_step = cfg_data[30:0];
				endcase
			end
			if (done) begin
				got = '{blocked, mark_dropped, steps_capped};
				if (expected_verdicts.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					if (got.blocked !== want.blocked) begin
						$error("blocked: expected %0d, got %0d", want.blocked, got.blocked);
						errors++;
					end
					if (got.dropped !== want.dropped) begin
						$error("mark_dropped: expected %0d, got %0d", want.dropped, got.dropped);
						errors++;
					end
					if (got.capped !== want.capped) begin
						$error("steps_capped: expected %0d, got %0d", want.capped, got.capped);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				want = '0;
				case (func_t'(func))
					FUNC_MARK:    want.dropped = mark_voxel(x1, y1, z1);
					FUNC_QUERY:   want.blocked = voxel_occupied(x1, y1, z1);
					FUNC_SEGMENT: want = judge_segment(x1, y1, z1, x2, y2, z2);
					default:      want = '0;
				endcase
				expected_verdicts.push_back(want);
			end
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// stimulus and verdict for the voxel occupancy segment checker
// depends on vosc_pkg, the block and vosc_checker
module tb;
	import vosc_pkg::*;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  func = FUNC_MARK;
	coord_t      x1 = '0, y1 = '0, z1 = '0, x2 = '0, y2 = '0, z2 = '0;
	logic        done, blocked, mark_dropped, steps_capped;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_LOWER_X;
	logic [31:0] cfg_data = '0;
	int          errors, pending;

	int          sent, got, cycles;
	int          n_mark, n_query, n_seg, n_other;
	longint      box_lo [3];
	longint      box_hi [3];
	bit          idling;
	point_t      marked[$];

	voxel_occupancy_segment_check dut (.*);

	vosc_checker chk (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done)
			got <= got + 1;
		if (cycles > 15000000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send(func_t f, point_t a, point_t b);
		if (idling && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		{x1, y1, z1} <= {a.x, a.y, a.z};
		{x2, y2, z2} <= {b.x, b.y, b.z};
		do @(posedge clk); while (busy);
		sent++;
		case (f)
			FUNC_MARK:    n_mark++;
			FUNC_QUERY:   n_query++;
			FUNC_SEGMENT: n_seg++;
			default:      n_other++;
		endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		while (got != sent) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// valid stays up across back-to-back writes; the caller drops it
	task automatic write_reg(cfg_reg_t r, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// lower, upper, voxel size, reciprocal; box spans the grid for well-formed points
	task automatic set_grid(logic [31:0] lo [3], logic [31:0] up [3], logic [31:0] vs,
			logic [31:0] inv);
		drain();
		write_reg(CFG_LOWER_X, lo[0]);
		write_reg(CFG_LOWER_Y, lo[1]);
		write_reg(CFG_LOWER_Z, lo[2]);
		write_reg(CFG_UPPER_X, up[0]);
		write_reg(CFG_UPPER_Y, up[1]);
		write_reg(CFG_UPPER_Z, up[2]);
		write_reg(CFG_VOXEL, vs);
		write_reg(CFG_INVVOXEL, inv);
		cfg_valid <= 1'b0;
		marked.delete();
		for (int a = 0; a < 3; a++) begin
			box_lo[a] = longint'(signed'(lo[a]));
			box_hi[a] = longint'(signed'(up[a]));
		end
	endtask

	function automatic coord_t pick_coord(int a);
		longint span;
		span = box_hi[a] - box_lo[a];
		if ($urandom_range(0, 9) < 2 || span > 64'h7000_0000 || span <= 1)
			return coord_t'($urandom);
		return coord_t'(box_lo[a] + longint'($urandom_range(0, int'(span) - 1)));
	endfunction

	function automatic point_t pick_point();
		point_t p;
		if (marked.size() != 0 && $urandom_range(0, 2) == 0)
			return marked[$urandom_range(0, marked.size() - 1)];
		p.x = pick_coord(0);
		p.y = pick_coord(1);
		p.z = pick_coord(2);
		return p;
	endfunction

	task automatic random_items(int count, bit quiet_tail);
		point_t a, b;
		int sel;
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0)
				idling = $urandom_range(0, 2) != 0;
			if (quiet_tail && k >= count / 2)
				idling = 1'b0;
			a = pick_point();
			b = pick_point();
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				send(FUNC_MARK, a, b);
				marked.push_back(a);
			end else if (sel < 70) begin
				send(FUNC_QUERY, a, b);
			end else if (sel < 95) begin
				send(FUNC_SEGMENT, a, b);
			end else begin
				send(FUNC_NONE, a, b);
			end
		end
	endtask

	function automatic point_t pt(longint x, longint y, longint z);
		point_t p;
		p.x = coord_t'(x);
		p.y = coord_t'(y);
		p.z = coord_t'(z);
		return p;
	endfunction

	initial begin
		logic [31:0] lo [3];
		logic [31:0] up [3];
		point_t o;
		for (int a = 0; a < 3; a++) begin
			box_lo[a] = 0;
			box_hi[a] = 64'd4194304;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		idling = 1'b0;
		o = pt(0, 0, 0);

		// directed: corners, out of bounds on each axis, clamping, segment cases
		send(FUNC_MARK, o, o);
		send(FUNC_MARK, pt(4194303, 4194303, 4194303), o);
		send(FUNC_MARK, pt(-1, 0, 0), o);
		send(FUNC_MARK, pt(0, 4194304, 0), o);
		send(FUNC_MARK, pt(0, 0, -65536), o);
		send(FUNC_MARK, pt(32'h7fffffff, 32'h7fffffff, 32'h7fffffff), o);
		send(FUNC_MARK, pt(32'sh80000000, 32'sh80000000, 32'sh80000000), o);
		send(FUNC_MARK, pt(20 << 16, 20 << 16, 20 << 16), o);
		send(FUNC_QUERY, o, o);
		send(FUNC_QUERY, pt(10 << 16, 10 << 16, 10 << 16), o);
		send(FUNC_QUERY, pt(32'h7fffffff, 32'h7fffffff, 32'h7fffffff), o);
		send(FUNC_QUERY, pt(32'sh80000000, 5 << 16, 5 << 16), o);
		send(FUNC_SEGMENT, pt(5 << 16, 5 << 16, 5 << 16), pt(5 << 16, 5 << 16, 5 << 16));
		send(FUNC_SEGMENT, pt(3 << 16, 3 << 16, 3 << 16), o);
		send(FUNC_SEGMENT, pt(10 << 16, 20 << 16, 20 << 16), pt(30 << 16, 20 << 16, 20 << 16));
		send(FUNC_SEGMENT, pt(1 << 16, 2 << 16, 9 << 16), pt(40 << 16, 50 << 16, 9 << 16));
		send(FUNC_SEGMENT, pt(32'sh80000000, 32'sh80000000, 32'sh80000000),
			pt(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send(FUNC_SEGMENT, pt(32'h7fffffff, 0, 0), pt(32'sh80000000, 0, 0));
		send(FUNC_NONE, pt(20 << 16, 20 << 16, 20 << 16), o);
		random_items(110, 1'b0);

		// half-size voxels with the grid shifted negative
		lo = '{-32'sd524288, -32'sd524288, -32'sd524288};
		up = '{32'd1572864, 32'd1572864, 32'd1572864};
		set_grid(lo, up, 32'd32768, 32'd131072);
		random_items(130, 1'b0);

		// bounds wider than the grid along x, smallest step so segments saturate
		lo = '{32'd0, 32'd0, 32'd0};
		up = '{32'h7fffffff, 32'd4194304, 32'd4194304};
		set_grid(lo, up, 32'd1, 32'd65536);
		box_hi[0] = 64'd8388608;
		send(FUNC_MARK, pt(100 << 16, 1 << 16, 1 << 16), o);
		random_items(90, 1'b0);

		// extreme bounds and scales: with the unit reciprocal every point lands in one voxel
		lo = '{32'h80000000, 32'h80000000, 32'h80000000};
		up = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		set_grid(lo, up, 32'h7fffffff, 32'd1);
		random_items(70, 1'b0);
		up = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		lo = '{32'h80000000, 32'h80000000, 32'h80000000};
		set_grid(lo, up, 32'd65536, 32'h7fffffff);
		random_items(60, 1'b0);

		// coarse voxels, last stretch without gaps
		lo = '{32'd1048576, 32'd1048576, 32'd1048576};
		up = '{32'd17825792, 32'd17825792, 32'd17825792};
		set_grid(lo, up, 32'd262144, 32'd16384);
		random_items(170, 1'b1);

		drain();
		$display("covered %0d marks, %0d point queries, %0d segments, %0d unused requests",
			n_mark, n_query, n_seg, n_other);
		$display("over six grid settings in %0d cycles", cycles);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/vosc_pkg.sv
hdl/vosc_mul.sv
hdl/vosc_queue.sv
hdl/vosc_front.sv
hdl/vosc_back.sv
hdl/voxel_occupancy_segment_check.sv
tb/vosc_checker.sv
tb/tb.sv
